[rtl/core/slrc_pkg.sv]
// ----------------------------------------------------------------------------
// slrc_pkg
// Shared types and constants of the set-associative LRU cache directory.
// ----------------------------------------------------------------------------
package slrc_pkg;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 104;
   localparam int CNT_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int SHIFT_W    = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_INDEX_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_OFFSET_BITS = 2'd2;

   localparam logic [3:0] RST_SET_INDEX_BITS    = 4'd4;
   localparam logic [3:0] RST_WAYS_IN_USE       = 4'd1;
   localparam logic [5:0] RST_BLOCK_OFFSET_BITS = 6'd4;

   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic hit;
      logic miss;
      logic evict;
   } slrc_flags_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

[rtl/core/slrc_row_mem.sv]
// ----------------------------------------------------------------------------
// slrc_row_mem
// Directory memory, one row per set, one write and one registered read port.
// ----------------------------------------------------------------------------
module slrc_row_mem
   import slrc_pkg::*;
#(
   parameter int ADDR_W = 10,
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 544
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/slrc_set_update.sv]
// ----------------------------------------------------------------------------
// slrc_set_update
// Lookup, victim choice and age-rank update of one set row.
// ----------------------------------------------------------------------------
module slrc_set_update
   import slrc_pkg::*;
#(
   parameter int MAX_WAYS = 8,
   parameter int TAG_W    = 64,
   localparam int AGE_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int WAY_CW  = $clog2(MAX_WAYS + 1),
   localparam int ENTRY_W = 1 + AGE_W + TAG_W,
   localparam int ROW_W   = MAX_WAYS * ENTRY_W
) (
   input  logic [ROW_W-1:0]  row_rd,
   input  logic [TAG_W-1:0]  tag,
   input  logic [WAY_CW-1:0] ways_eff,
   output logic [ROW_W-1:0]  row_wr,
   output slrc_flags_type    flags
);

   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

   logic [MAX_WAYS-1:0] valid;
   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] hit_vec;
   logic [AGE_W-1:0]    age [MAX_WAYS];
   logic [TAG_W-1:0]    tag_rd [MAX_WAYS];
   logic                is_hit;
   logic [WAY_W-1:0]    hit_way;
   logic [AGE_W-1:0]    hit_age;
   logic                found_inv;
   logic [WAY_W-1:0]    inv_way;
   logic                found_lru;
   logic [WAY_W-1:0]    lru_way;
   logic [AGE_W-1:0]    lru_age;
   logic [WAY_W-1:0]    victim;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         valid[w]   = row_rd[w*ENTRY_W + TAG_W + AGE_W];
         age[w]     = row_rd[w*ENTRY_W + TAG_W +: AGE_W];
         tag_rd[w]  = row_rd[w*ENTRY_W +: TAG_W];
         in_use[w]  = (WAY_CW'(w) < ways_eff);
         hit_vec[w] = in_use[w] && valid[w] && (tag_rd[w] == tag);
      end
   end

   always_comb begin
      is_hit    = 1'b0;
      hit_way   = '0;
      hit_age   = '0;
      found_inv = 1'b0;
      inv_way   = '0;
      found_lru = 1'b0;
      lru_way   = '0;
      lru_age   = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (hit_vec[w] && !is_hit) begin
            is_hit  = 1'b1;
            hit_way = WAY_W'(w);
            hit_age = age[w];
         end
         if (in_use[w] && !valid[w] && !found_inv) begin
            found_inv = 1'b1;
            inv_way   = WAY_W'(w);
         end
         if (in_use[w] && (!found_lru || age[w] > lru_age)) begin
            found_lru = 1'b1;
            lru_way   = WAY_W'(w);
            lru_age   = age[w];
         end
      end
      victim = found_inv ? inv_way : lru_way;
   end

   always_comb begin
      row_wr = row_rd;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (is_hit) begin
            if (in_use[w] && valid[w]) begin
               if (WAY_W'(w) == hit_way) begin
                  row_wr[w*ENTRY_W + TAG_W +: AGE_W] = '0;
               end else if (age[w] < hit_age && age[w] < AGE_MAX) begin
                  row_wr[w*ENTRY_W + TAG_W +: AGE_W] = age[w] + 1'b1;
               end
            end
         end else begin
            if (WAY_W'(w) == victim) begin
               row_wr[w*ENTRY_W + TAG_W + AGE_W]  = 1'b1;
               row_wr[w*ENTRY_W + TAG_W +: AGE_W] = '0;
               row_wr[w*ENTRY_W +: TAG_W]         = tag;
            end else if (in_use[w] && valid[w] && age[w] < AGE_MAX) begin
               row_wr[w*ENTRY_W + TAG_W +: AGE_W] = age[w] + 1'b1;
            end
         end
      end
   end

   assign flags.hit   = is_hit;
   assign flags.miss  = !is_hit;
   assign flags.evict = !is_hit && !found_inv;

endmodule

[rtl/core/set_assoc_lru_cache_sim_top.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_top
// Set-associative cache directory with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each word on the req_ channel is one trace access (operation, address).
// The block answers every access with one word on the rsp_ channel that
// carries the hit, miss, eviction and second-hit flags and the saturating
// running totals. The csr_ channel writes set_index_bits (index 0),
// ways_in_use (index 1) and block_offset_bits (index 2); csr_ready is
// always high, and every write to a listed register invalidates the whole
// directory while the totals are kept.
// On an access, the set row is read from the directory memory at the accept
// edge; in the update state, once the output register is free or its result
// is being taken, the row is looked up, updated, written back and the result
// word is loaded. A new access is taken only after the current one has left
// the update state.
// After reset and after each write to a listed register, a clearing pass walks
// the directory memory one set per cycle over all 2**MAX_SET_BITS sets (1024 by
// default), with req_tready low. When the receiver stalls, one finished
// result waits in the output register and one more access is taken; that
// access then waits until the result ahead of it has been taken.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_top
   import slrc_pkg::*;
#(
   parameter int MAX_WAYS      = 8,
   parameter int MAX_SET_BITS  = 10,
   parameter int ADDRESS_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // operation [1:0], address [65:2], zero fill [71:66]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // first_hit [0], first_miss [1], evicted [2], second_hit [3],
   // hit_total [35:4], miss_total [67:36], eviction_total [99:68], zero fill [103:100]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SET_AW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int SET_COUNT = 1 << MAX_SET_BITS;
   localparam int AGE_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_CW    = $clog2(MAX_WAYS + 1);
   localparam int ENTRY_W   = 1 + AGE_W + ADDRESS_WIDTH;
   localparam int ROW_W     = MAX_WAYS * ENTRY_W;

   localparam logic [SET_AW-1:0] CLR_LAST = SET_AW'(SET_COUNT - 1);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [SET_AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [3:0]               set_bits_ff;
   logic [3:0]               ways_ff;
   logic [5:0]               offset_bits_ff;
   logic [1:0]               op_ff;
   logic [ADDRESS_WIDTH-1:0] tag_ff;
   logic [SET_AW-1:0]        set_ff;
   logic                     rsp_tvalid_ff;
   logic [3:0]               rsp_flags_ff;
   logic [CNT_W-1:0]         hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]         miss_cnt_ff;
   logic [CNT_W-1:0]         evict_cnt_ff;
   logic [CNT_W-1:0]         hit_first;

   logic [1:0]               req_op;
   logic [ADDRESS_WIDTH-1:0] req_addr;
   logic [SHIFT_W-1:0]       set_bits_eff;
   logic [SHIFT_W-1:0]       tag_shift;
   logic [ADDRESS_WIDTH-1:0] req_tag;
   logic [ADDRESS_WIDTH-1:0] set_shifted;
   logic [SET_AW-1:0]        set_mask;
   logic [SET_AW-1:0]        req_set;
   logic [WAY_CW-1:0]        ways_eff;
   logic                     req_accept;
   logic                     upd_go;
   logic                     csr_known;
   logic                     access;
   logic                     f_hit;
   logic                     f_miss;
   logic                     f_evict;
   logic                     f_second;
   logic                     mem_wr_en;
   logic [SET_AW-1:0]        mem_wr_addr;
   logic [ROW_W-1:0]         mem_wr_data;
   logic [ROW_W-1:0]         row_rd;
   logic [ROW_W-1:0]         row_new;
   slrc_flags_type           flags;

   assign req_op   = req_tdata[1:0];
   assign req_addr = req_tdata[2 +: ADDRESS_WIDTH];

   assign set_bits_eff = (int'(set_bits_ff) > MAX_SET_BITS) ? SHIFT_W'(MAX_SET_BITS)
                                                            : SHIFT_W'(set_bits_ff);
   assign tag_shift    = set_bits_eff + SHIFT_W'(offset_bits_ff);
   assign req_tag      = req_addr >> tag_shift;
   assign set_shifted  = req_addr >> offset_bits_ff;

   always_comb begin
      for (int i = 0; i < SET_AW; i++) begin
         set_mask[i] = (SHIFT_W'(i) < set_bits_eff);
      end
   end

   assign req_set = set_shifted[SET_AW-1:0] & set_mask;

   always_comb begin
      if (ways_ff == 4'd0) begin
         ways_eff = WAY_CW'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = WAY_CW'(MAX_WAYS);
      end else begin
         ways_eff = WAY_CW'(ways_ff);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign upd_go     = (state_ff == S_UPDATE) && (!rsp_tvalid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign csr_known  = (csr_index == CSR_SET_INDEX_BITS) ||
                       (csr_index == CSR_WAYS_IN_USE) ||
                       (csr_index == CSR_BLOCK_OFFSET_BITS);

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (upd_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      if (csr_valid && csr_known) begin
         state_in   = S_CLEAR;
         clr_cnt_in = '0;
      end
   end

   slrc_row_mem #(
      .ADDR_W (SET_AW),
      .DEPTH  (SET_COUNT),
      .DATA_W (ROW_W)
   ) u_row_mem (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (req_set),
      .rd_data (row_rd),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   slrc_set_update #(
      .MAX_WAYS (MAX_WAYS),
      .TAG_W    (ADDRESS_WIDTH)
   ) u_set_update (
      .row_rd   (row_rd),
      .tag      (tag_ff),
      .ways_eff (ways_eff),
      .row_wr   (row_new),
      .flags    (flags)
   );

   assign access    = (op_ff != OP_NONE);
   assign f_hit     = access && flags.hit;
   assign f_miss    = access && flags.miss;
   assign f_evict   = access && flags.evict;
   assign f_second  = (op_ff == OP_MODIFY);

   assign mem_wr_en   = (state_ff == S_CLEAR) || (upd_go && access);
   assign mem_wr_addr = (state_ff == S_CLEAR) ? clr_cnt_ff : set_ff;
   assign mem_wr_data = (state_ff == S_CLEAR) ? '0 : row_new;

   assign hit_first  = f_hit ? sat_inc(hit_cnt_ff) : hit_cnt_ff;
   assign hit_cnt_in = f_second ? sat_inc(hit_first) : hit_first;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_cnt_ff     <= '0;
         set_bits_ff    <= RST_SET_INDEX_BITS;
         ways_ff        <= RST_WAYS_IN_USE;
         offset_bits_ff <= RST_BLOCK_OFFSET_BITS;
         rsp_tvalid_ff  <= 1'b0;
         hit_cnt_ff     <= '0;
         miss_cnt_ff    <= '0;
         evict_cnt_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SET_INDEX_BITS:    set_bits_ff    <= csr_data[3:0];
               CSR_WAYS_IN_USE:       ways_ff        <= csr_data[3:0];
               CSR_BLOCK_OFFSET_BITS: offset_bits_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (upd_go) begin
            rsp_tvalid_ff <= 1'b1;
            hit_cnt_ff    <= hit_cnt_in;
            if (f_miss) begin
               miss_cnt_ff <= sat_inc(miss_cnt_ff);
            end
            if (f_evict) begin
               evict_cnt_ff <= sat_inc(evict_cnt_ff);
            end
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_op;
         tag_ff <= req_tag;
         set_ff <= req_set;
      end
      if (upd_go) begin
         rsp_flags_ff <= {f_second, f_evict, f_miss, f_hit};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0000, evict_cnt_ff, miss_cnt_ff, hit_cnt_ff, rsp_flags_ff};

   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !csr_valid) |=> (state_ff == S_UPDATE))
      else $error("accepted access did not move to the update cycle");

   a_hit_monotone: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (hit_cnt_ff >= $past(hit_cnt_ff)))
      else $error("hit total decreased");

   a_evict_le_miss: assert property (@(posedge clock) disable iff (reset)
      evict_cnt_ff <= miss_cnt_ff)
      else $error("eviction total exceeds miss total");

   a_flags_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (!(rsp_flags_ff[0] && rsp_flags_ff[1])
                         && (!rsp_flags_ff[2] || rsp_flags_ff[1])))
      else $error("result flags inconsistent");

endmodule
